// ===== hw/rtl/sem_pkg.sv =====
// shared types and constants for the sobel edge magnitude block
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package sem_pkg;

  localparam int PixW     = 8;   // pixel and magnitude width
  localparam int CfgDataW = 11;  // widest configuration register
  localparam int CfgIdxW  = 1;   // configuration register index width

  localparam int DefMaxWidth      = 1024;
  localparam int DefMaxHeight     = 1024;
  localparam int ResetImageWidth  = 640;
  localparam int ResetImageHeight = 480;

  localparam logic [PixW-1:0] MagMax = 8'd255;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth  = 1'b0,
    CfgImageHeight = 1'b1
  } cfg_idx_e;

endpackage

`default_nettype wire

// ===== hw/rtl/sem_pix_if.sv =====
// input pixel channel: valid/ready handshake with pixel and flush payload
// depends on sem_pkg
`default_nettype none

interface sem_pix_if;
  import sem_pkg::*;

  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel;
  logic            flush;

  modport source (output valid, pixel, flush, input ready);
  modport sink   (input valid, pixel, flush, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sem_res_if.sv =====
// result channel: valid/ready handshake with magnitude and last-pixel flag
// depends on sem_pkg
`default_nettype none

interface sem_res_if;
  import sem_pkg::*;

  logic            valid;
  logic            ready;
  logic [PixW-1:0] edge_res;
  logic            last;

  modport source (output valid, edge_res, last, input ready);
  modport sink   (input valid, edge_res, last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sobel_edge_magnitude.sv =====
// streaming 3x3 sobel edge magnitude with two line buffer memories
// depends on sem_pkg, sem_pix_if and sem_res_if
//
//   channel   dir  handshake               payload
//   pix_i     in   valid/ready             pixel[7:0], flush
//   res_o     out  valid/ready             edge_res[7:0], last
//   cfg       in   cfg_we_i (no wait)      cfg_idx_i, cfg_data_i[10:0]
//
// one pixel transaction per cycle while pix_i.ready is high: the line buffers are read one column
// ahead, so the read-modify-write of a column fits in the accept cycle
// the result register is the last of six stages behind the pixel transaction that
// completes the window (masked window, gradient, squares, sum, two four-bit
// square root stages)
// no clearing pass after reset: line buffer entries never written are
// always masked off at the image border
// a held result does not block input until all six stages are occupied
`default_nettype none

module sobel_edge_magnitude #(
  parameter int MAX_WIDTH  = sem_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = sem_pkg::DefMaxHeight
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sem_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sem_pkg::CfgDataW-1:0] cfg_data_i,
  sem_pix_if.sink                      pix_i,
  sem_res_if.source                    res_o
);
  import sem_pkg::*;

  // counter widths
  localparam int ColW    = $clog2(MAX_WIDTH);       // column, memory address
  localparam int WidW    = $clog2(MAX_WIDTH + 1);   // effective width
  localparam int ColCmpW = ColW + 1;
  localparam int OrowW   = $clog2(MAX_HEIGHT);      // output row
  localparam int HgtW    = $clog2(MAX_HEIGHT + 1);  // effective height
  localparam int IrowW   = $clog2(MAX_HEIGHT + 2);  // input row runs one past
  localparam int NStg    = 6;

  localparam int ResetW = (ResetImageWidth > MAX_WIDTH) ? MAX_WIDTH : ResetImageWidth;
  localparam int ResetH = (ResetImageHeight > MAX_HEIGHT) ? MAX_HEIGHT : ResetImageHeight;

  typedef struct packed {
    logic [10:0] rem;
    logic [7:0]  root;
  } sqrt_t;

  // four radix-2 steps of a digit-recurrence square root
  function automatic sqrt_t sqrt_step4(sqrt_t s_in, logic [7:0] bits);
    sqrt_t       s;
    logic [10:0] trial;
    s = s_in;
    for (int i = 3; i >= 0; i--) begin
      s.rem = {s.rem[8:0], bits[2*i+1 -: 2]};
      trial = {1'b0, s.root, 2'b01};
      if (s.rem >= trial) begin
        s.rem  = s.rem - trial;
        s.root = {s.root[6:0], 1'b1};
      end else begin
        s.root = {s.root[6:0], 1'b0};
      end
    end
    return s;
  endfunction

  // configuration and position state
  logic [WidW-1:0]  width_q, width_d;
  logic [HgtW-1:0]  height_q, height_d;
  logic [ColW-1:0]  col_in_q, col_in_d;
  logic [IrowW-1:0] row_in_q, row_in_d;
  logic [ColW-1:0]  col_out_q, col_out_d;
  logic [OrowW-1:0] row_out_q, row_out_d;
  logic [31:0]      cfg_ext;

  // line buffers and forwarding
  logic [PixW-1:0] abv_mem [MAX_WIDTH];
  logic [PixW-1:0] cur_mem [MAX_WIDTH];
  logic [PixW-1:0] abv_rd_q, cur_rd_q;
  logic [PixW-1:0] abv_fw_q, cur_fw_q;
  logic            fwd_q, fwd_d;

  // window and front end
  logic [PixW-1:0] win_q [9];
  logic [PixW-1:0] win_d [9];
  logic [PixW-1:0] p_msk [9];
  logic [PixW-1:0] a_px, c_px, v_px;
  logic            acc, emit, col_wrap;
  logic            top, bot, lft, rgt, last_px;

  // pipeline
  logic [NStg:1]    v_q, ld, lst_q;
  logic [PixW-1:0]  p1_q [9];
  logic signed [10:0] gx_d, gy_d, gx2_q, gy2_q;
  logic signed [21:0] sqx, sqy;
  logic [19:0]      sqx3_q, sqy3_q;
  logic [20:0]      sum4;
  logic [15:0]      n4_q;
  logic             sat4_q, sat5_q;
  logic [7:0]       lo5_q;
  sqrt_t            s5_d, s5_q, s6;
  logic [PixW-1:0]  mag6_q;

  // stall chain: a stage loads when empty or when its content moves on
  always_comb begin
    ld[NStg] = ~v_q[NStg] | res_o.ready;
    for (int k = NStg - 1; k >= 1; k--) begin
      ld[k] = ~v_q[k] | ld[k+1];
    end
  end

  assign pix_i.ready = ld[1];
  assign acc         = pix_i.valid & pix_i.ready;

  // column data, forwarded when last cycle wrote the column being read
  assign a_px = fwd_q ? abv_fw_q : abv_rd_q;
  assign c_px = fwd_q ? cur_fw_q : cur_rd_q;
  assign v_px = pix_i.flush ? '0 : pix_i.pixel;

  // window shifts left, new column enters on the right
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r*3]     = win_q[r*3];
      win_d[r*3 + 1] = win_q[r*3 + 1];
      win_d[r*3 + 2] = win_q[r*3 + 2];
    end
    if (acc) begin
      for (int r = 0; r < 3; r++) begin
        win_d[r*3]     = win_q[r*3 + 1];
        win_d[r*3 + 1] = win_q[r*3 + 2];
      end
      win_d[2] = a_px;
      win_d[5] = c_px;
      win_d[8] = v_px;
    end
  end

  // border flags of the output position
  assign top     = (row_out_q == '0);
  assign bot     = (IrowW'(row_out_q) + IrowW'(1)) >= IrowW'(height_q);
  assign lft     = (col_out_q == '0);
  assign rgt     = (ColCmpW'(col_out_q) + ColCmpW'(1)) >= ColCmpW'(width_q);
  assign last_px = bot & rgt;

  // a result exists once the lower-right neighbour arrives
  assign emit = (row_in_q >= IrowW'(2)) ||
                ((row_in_q == IrowW'(1)) && (col_in_q != '0));
  assign col_wrap = (ColCmpW'(col_in_q) + ColCmpW'(1)) >= ColCmpW'(width_q);

  // pixels outside the image count as zero
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((r == 0 && top) || (r == 2 && bot) || (c == 0 && lft) || (c == 2 && rgt)) begin
          p_msk[r*3 + c] = '0;
        end else begin
          p_msk[r*3 + c] = win_d[r*3 + c];
        end
      end
    end
  end

  // counters and configuration
  always_comb begin
    width_d   = width_q;
    height_d  = height_q;
    col_in_d  = col_in_q;
    row_in_d  = row_in_q;
    col_out_d = col_out_q;
    row_out_d = row_out_q;
    cfg_ext   = 32'(cfg_data_i);

    if (acc) begin
      col_in_d = col_wrap ? '0 : col_in_q + ColW'(1);
      row_in_d = col_wrap ? row_in_q + IrowW'(1) : row_in_q;
      if (emit) begin
        if (last_px) begin
          // final pixel of the frame: the next transaction starts a new one
          col_in_d  = '0;
          row_in_d  = '0;
          col_out_d = '0;
          row_out_d = '0;
        end else begin
          col_out_d = rgt ? '0 : col_out_q + ColW'(1);
          row_out_d = rgt ? row_out_q + OrowW'(1) : row_out_q;
        end
      end
    end

    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgImageWidth: begin
          if (cfg_ext == 32'd0) begin
            width_d = WidW'(1);
          end else if (cfg_ext > 32'(MAX_WIDTH)) begin
            width_d = WidW'(MAX_WIDTH);
          end else begin
            width_d = WidW'(cfg_ext);
          end
        end
        CfgImageHeight: begin
          if (cfg_ext == 32'd0) begin
            height_d = HgtW'(1);
          end else if (cfg_ext > 32'(MAX_HEIGHT)) begin
            height_d = HgtW'(MAX_HEIGHT);
          end else begin
            height_d = HgtW'(cfg_ext);
          end
        end
        default: begin
        end
      endcase
      // any register write restarts the frame
      col_in_d  = '0;
      row_in_d  = '0;
      col_out_d = '0;
      row_out_d = '0;
    end
  end

  // read and write hit the same column when the row is one pixel wide and on
  // the final transaction of a frame, which sits in column zero
  assign fwd_d = acc & (col_in_d == col_in_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WidW'(ResetW);
      height_q  <= HgtW'(ResetH);
      col_in_q  <= '0;
      row_in_q  <= '0;
      col_out_q <= '0;
      row_out_q <= '0;
      fwd_q     <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end else begin
      width_q   <= width_d;
      height_q  <= height_d;
      col_in_q  <= col_in_d;
      row_in_q  <= row_in_d;
      col_out_q <= col_out_d;
      row_out_q <= row_out_d;
      fwd_q     <= fwd_d;
      win_q     <= win_d;
    end
  end

  // line buffers: row above takes the old current-row pixel
  always_ff @(posedge clk_i) begin
    if (acc) begin
      abv_mem[col_in_q] <= c_px;
      cur_mem[col_in_q] <= v_px;
      abv_fw_q          <= c_px;
      cur_fw_q          <= v_px;
    end
    abv_rd_q <= abv_mem[col_in_d];
    cur_rd_q <= cur_mem[col_in_d];
  end

  // gradients, range +-1020
  always_comb begin
    gx_d = -$signed({3'b0, p1_q[0]}) - ($signed({3'b0, p1_q[1]}) <<< 1)
           - $signed({3'b0, p1_q[2]}) + $signed({3'b0, p1_q[6]})
           + ($signed({3'b0, p1_q[7]}) <<< 1) + $signed({3'b0, p1_q[8]});
    gy_d = -$signed({3'b0, p1_q[0]}) - ($signed({3'b0, p1_q[3]}) <<< 1)
           - $signed({3'b0, p1_q[6]}) + $signed({3'b0, p1_q[2]})
           + ($signed({3'b0, p1_q[5]}) <<< 1) + $signed({3'b0, p1_q[8]});
  end

  assign sqx  = gx2_q * gx2_q;
  assign sqy  = gy2_q * gy2_q;
  assign sum4 = {1'b0, sqx3_q} + {1'b0, sqy3_q};
  assign s5_d = sqrt_step4('0, n4_q[15:8]);
  assign s6   = sqrt_step4(s5_q, lo5_q);

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[1]) begin
        v_q[1] <= acc & emit;
      end
      for (int k = 2; k <= NStg; k++) begin
        if (ld[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      p1_q     <= p_msk;
      lst_q[1] <= last_px;
    end
    for (int k = 2; k <= NStg; k++) begin
      if (ld[k]) begin
        lst_q[k] <= lst_q[k-1];
      end
    end
    if (ld[2]) begin
      gx2_q <= gx_d;
      gy2_q <= gy_d;
    end
    if (ld[3]) begin
      sqx3_q <= sqx[19:0];
      sqy3_q <= sqy[19:0];
    end
    if (ld[4]) begin
      n4_q   <= sum4[15:0];
      sat4_q <= (sum4[20:16] != '0);
    end
    if (ld[5]) begin
      s5_q   <= s5_d;
      lo5_q  <= n4_q[7:0];
      sat5_q <= sat4_q;
    end
    if (ld[6]) begin
      mag6_q <= sat5_q ? MagMax : s6.root;
    end
  end

  assign res_o.valid    = v_q[NStg];
  assign res_o.edge_res = mag6_q;
  assign res_o.last     = lst_q[NStg];

endmodule

`default_nettype wire
